// ===== rtl/tls_record_deframer_macros.svh =====
// Assertion helpers for the checker file, rtl/trd_checker.sv.
`ifndef TLS_RECORD_DEFRAMER_MACROS_SVH
`define TLS_RECORD_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define TRD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle, consequence in the next.
`define TRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/trd_pkg.sv =====
package trd_pkg;

    // Record header is type, version (2 bytes), length (2 bytes).
    localparam int HEADER_BYTES = 5;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;

    // Queue between the byte intake and the record parser.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    typedef struct packed {
        logic       dir;
        logic [7:0] data;
    } q_entry_t;

    // Per-direction parse phase: one code per header byte, then payload.
    typedef enum logic [HEADER_BYTES:0] {
        PH_TYPE    = 6'b000001,
        PH_VER_HI  = 6'b000010,
        PH_VER_LO  = 6'b000100,
        PH_LEN_HI  = 6'b001000,
        PH_LEN_LO  = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

endpackage

// ===== rtl/trd_front.sv =====
module trd_front #(
    parameter int NUM_DIRECTIONS = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [trd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]                      s_axis_tuser,   // [0] dir_sel
    output logic                            q_valid,
    output trd_pkg::q_entry_t               q_entry,
    input  logic                            q_pop
);

    trd_pkg::q_entry_t                 q_mem_reg [trd_pkg::QUEUE_DEPTH];
    logic [trd_pkg::QUEUE_AW-1:0]      wr_ptr_reg;
    logic [trd_pkg::QUEUE_AW-1:0]      rd_ptr_reg;
    logic [trd_pkg::QUEUE_CW-1:0]      count_reg;
    logic [trd_pkg::QUEUE_CW-1:0]      count_next;
    logic                              in_range;
    logic                              push;
    logic                              pop;

    // Drop words for directions the block does not track.
    assign in_range      = int'(s_axis_tuser[0]) < NUM_DIRECTIONS;
    assign s_axis_tready = count_reg != trd_pkg::QUEUE_CW'(trd_pkg::QUEUE_DEPTH);
    assign push          = s_axis_tvalid && s_axis_tready && in_range;
    assign q_valid       = count_reg != '0;
    assign pop           = q_pop && q_valid;
    assign q_entry       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + trd_pkg::QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - trd_pkg::QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= '{dir: s_axis_tuser[0], data: s_axis_tdata};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + trd_pkg::QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + trd_pkg::QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/trd_back.sv =====
module trd_back #(
    parameter int NUM_DIRECTIONS = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  trd_pkg::q_entry_t               q_entry,
    output logic                            q_pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [trd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);

    localparam int DIR_W = (NUM_DIRECTIONS > 1) ? $clog2(NUM_DIRECTIONS) : 1;

    trd_pkg::phase_t   phase_reg [NUM_DIRECTIONS];
    logic [7:0]        type_reg  [NUM_DIRECTIONS];
    logic [15:0]       ver_reg   [NUM_DIRECTIONS];
    logic [15:0]       len_reg   [NUM_DIRECTIONS];
    logic [15:0]       pc_reg    [NUM_DIRECTIONS];

    logic [DIR_W-1:0]  dir_idx;
    trd_pkg::phase_t   cur_phase;
    trd_pkg::phase_t   phase_next;
    logic [7:0]        type_next;
    logic [15:0]       ver_next;
    logic [15:0]       len_next;
    logic [15:0]       pc_next;
    logic [15:0]       cur_pc;
    logic [15:0]       cur_len;
    logic              fin;
    logic              emit;
    logic [7:0]        res_byte;
    logic [15:0]       res_offset;
    logic              res_has;
    logic              res_last;
    logic              advance;

    logic                            out_valid_reg;
    logic [trd_pkg::OUT_TDATA_W-1:0] out_tdata_reg;
    logic                            out_has_reg;
    logic                            out_last_reg;

    // Take the next queued word whenever the output slot is free or draining.
    assign advance = q_valid && (!out_valid_reg || m_axis_tready);
    assign q_pop   = advance;

    assign dir_idx   = DIR_W'(q_entry.dir);
    assign cur_phase = phase_reg[dir_idx];
    assign cur_pc    = pc_reg[dir_idx];
    assign cur_len   = len_reg[dir_idx];
    assign fin       = ({1'b0, cur_pc} + 17'd1) >= {1'b0, cur_len};

    always_comb
    begin
        phase_next = cur_phase;
        type_next  = type_reg[dir_idx];
        ver_next   = ver_reg[dir_idx];
        len_next   = cur_len;
        pc_next    = cur_pc;
        emit       = 1'b0;
        res_byte   = 8'h00;
        res_offset = 16'h0000;
        res_has    = 1'b0;
        res_last   = 1'b0;
        unique case (cur_phase)
            trd_pkg::PH_TYPE:
            begin
                type_next  = q_entry.data;
                phase_next = trd_pkg::PH_VER_HI;
            end
            trd_pkg::PH_VER_HI:
            begin
                ver_next   = {q_entry.data, 8'h00};
                phase_next = trd_pkg::PH_VER_LO;
            end
            trd_pkg::PH_VER_LO:
            begin
                ver_next   = {ver_reg[dir_idx][15:8], q_entry.data};
                phase_next = trd_pkg::PH_LEN_HI;
            end
            trd_pkg::PH_LEN_HI:
            begin
                len_next   = {q_entry.data, 8'h00};
                phase_next = trd_pkg::PH_LEN_LO;
            end
            trd_pkg::PH_LEN_LO:
            begin
                len_next = {cur_len[15:8], q_entry.data};
                pc_next  = 16'h0000;
                if (len_next == 16'h0000)
                begin
                    // empty record: one marker word with no byte
                    emit       = 1'b1;
                    res_last   = 1'b1;
                    phase_next = trd_pkg::PH_TYPE;
                end
                else
                begin
                    phase_next = trd_pkg::PH_PAYLOAD;
                end
            end
            trd_pkg::PH_PAYLOAD:
            begin
                emit       = 1'b1;
                res_byte   = q_entry.data;
                res_offset = cur_pc;
                res_has    = 1'b1;
                res_last   = fin;
                if (fin)
                begin
                    pc_next    = 16'h0000;
                    phase_next = trd_pkg::PH_TYPE;
                end
                else
                begin
                    pc_next = cur_pc + 16'd1;
                end
            end
            default:
            begin
                phase_next = trd_pkg::PH_TYPE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIRECTIONS; i++)
            begin
                phase_reg[i] <= trd_pkg::PH_TYPE;
                type_reg[i]  <= '0;
                ver_reg[i]   <= '0;
                len_reg[i]   <= '0;
                pc_reg[i]    <= '0;
            end
        end
        else if (advance)
        begin
            phase_reg[dir_idx] <= phase_next;
            type_reg[dir_idx]  <= type_next;
            ver_reg[dir_idx]   <= ver_next;
            len_reg[dir_idx]   <= len_next;
            pc_reg[dir_idx]    <= pc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_tdata_reg <= {7'b0, res_offset, res_byte, len_next, ver_next, type_next,
                              q_entry.dir};
            out_has_reg   <= res_has;
            out_last_reg  <= res_last;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_tdata_reg;
    assign m_axis_tuser[0] = out_has_reg;
    assign m_axis_tlast    = out_last_reg;

endmodule

// ===== rtl/tls_record_deframer.sv =====
// TLS record deframer. Takes one TCP payload byte per word, tagged with its
// direction on s_axis_tuser, and per direction collects the 5-byte record
// header (type, big-endian version, big-endian length), then passes the
// payload bytes through, one result word per byte, each carrying the header
// fields, its offset in the record and tlast on the final byte. A record of
// length zero gives a single word with has_byte clear. Header bytes give no
// word; bytes of a direction at or above NUM_DIRECTIONS are dropped. The
// block takes one byte per cycle while s_axis_tready is high; tready drops
// while the 4-entry queue is full. The queue feeds the record parser, whose
// per-direction counters are registered, and a registered output slot hands
// results on. A byte taken is written into the queue and then registered into
// the output slot, later when words wait ahead of it or the output is stalled.
module tls_record_deframer #(
    parameter int NUM_DIRECTIONS = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [trd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]                      s_axis_tuser,   // [0] dir_sel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] out_dir, [8:1] record_type, [24:9] proto_version,
    // [40:25] record_length, [48:41] payload_byte, [64:49] byte_offset, [71:65] zero
    output logic [trd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]                      m_axis_tuser,   // [0] has_byte
    output logic                            m_axis_tlast
);

    logic              q_valid;
    logic              q_pop;
    trd_pkg::q_entry_t q_entry;

    trd_front #(
        .NUM_DIRECTIONS (NUM_DIRECTIONS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop)
    );

    trd_back #(
        .NUM_DIRECTIONS (NUM_DIRECTIONS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/trd_checker.sv =====
`include "tls_record_deframer_macros.svh"

module trd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [trd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                      m_axis_tuser,
    input logic                            m_axis_tlast
);

    // A stalled result holds its word.
    `TRD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

    // An empty-record word ends its record and carries no byte or offset.
    `TRD_ASSERT(a_empty_rec, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && (m_axis_tdata[64:41] == 24'h0)), "empty record word malformed")

    // The last byte sits at offset length-1.
    `TRD_ASSERT(a_last_off, (m_axis_tvalid && m_axis_tuser[0] && m_axis_tlast) |-> ((m_axis_tdata[64:49] + 16'd1) == m_axis_tdata[40:25]), "last byte offset mismatch")

    // Any other byte lies strictly inside the record.
    `TRD_ASSERT(a_mid_off, (m_axis_tvalid && m_axis_tuser[0] && !m_axis_tlast) |-> ((17'(m_axis_tdata[64:49]) + 17'd1) < 17'(m_axis_tdata[40:25])), "byte offset past record end")

endmodule

bind tls_record_deframer trd_checker u_trd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
